// ===== src/i2cmw_pkg.sv =====
package i2cmw_pkg;

    localparam int TPU_W  = 10;
    localparam int WAIT_W = 13;
    localparam int US_W   = 3;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_HI  = 4'd1,
        PH_START_LO  = 4'd2,
        PH_BIT_LOW   = 4'd3,
        PH_BIT_SETUP = 4'd4,
        PH_BIT_HIGH  = 4'd5,
        PH_ACK_LOW   = 4'd6,
        PH_ACK_HIGH  = 4'd7,
        PH_STOP_PRE  = 4'd8,
        PH_STOP_LOW  = 4'd9,
        PH_STOP_HIGH = 4'd10
    } t_phase;

    localparam logic [US_W-1:0] US_START_HI  = 3'd6;
    localparam logic [US_W-1:0] US_START_LO  = 3'd5;
    localparam logic [US_W-1:0] US_BIT_LOW   = 3'd1;
    localparam logic [US_W-1:0] US_BIT_SETUP = 3'd2;
    localparam logic [US_W-1:0] US_BIT_HIGH  = 3'd1;
    localparam logic [US_W-1:0] US_ACK       = 3'd3;
    localparam logic [US_W-1:0] US_STOP_PRE  = 3'd2;
    localparam logic [US_W-1:0] US_STOP_LOW  = 3'd2;
    localparam logic [US_W-1:0] US_STOP_HIGH = 3'd6;

    localparam logic [WAIT_W-1:0] WAIT_MAX = WAIT_W'(6 * 1023);

    typedef struct packed {
        logic       func;
        logic [6:0] device_address;
        logic [7:0] register_index;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic scl_held_low;
        logic sda_driven;
        logic sda_value;
        logic busy_res;
        logic done_res;
        logic request_rejected;
    } t_out_item;

    function automatic logic [WAIT_W-1:0] load_wait(
        input logic [US_W-1:0]  us,
        input logic [TPU_W-1:0] tpu
    );
        logic [TPU_W-1:0]  tpu_eff;
        logic [WAIT_W-1:0] prod;
        tpu_eff = (tpu == '0) ? TPU_W'(1) : tpu;
        prod    = WAIT_W'(tpu_eff) * WAIT_W'(us);
        return prod;
    endfunction

endpackage

// ===== src/i2cmw_seq.sv =====
module i2cmw_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ce,
    input  i2cmw_pkg::t_in_item          i_item,
    input  logic [i2cmw_pkg::TPU_W-1:0]  i_tpu,
    output i2cmw_pkg::t_out_item         o_res
);

    i2cmw_pkg::t_phase               r_phase, n_phase;
    logic [1:0]                      r_byte, n_byte;
    logic [2:0]                      r_bit, n_bit;
    logic [i2cmw_pkg::WAIT_W-1:0]    r_wait, n_wait;
    logic [7:0]                      r_shift, n_shift;
    logic [7:0]                      r_reg_idx, n_reg_idx;
    logic [7:0]                      r_wdata, n_wdata;
    logic                            r_scl_low, n_scl_low;
    logic                            r_sda_oe, n_sda_oe;
    logic                            r_sda_lvl, n_sda_lvl;
    logic                            w_done;
    logic                            w_rej;

    always_comb begin
        n_phase   = r_phase;
        n_byte    = r_byte;
        n_bit     = r_bit;
        n_wait    = r_wait;
        n_shift   = r_shift;
        n_reg_idx = r_reg_idx;
        n_wdata   = r_wdata;
        n_scl_low = r_scl_low;
        n_sda_oe  = r_sda_oe;
        n_sda_lvl = r_sda_lvl;
        w_done    = 1'b0;
        w_rej     = 1'b0;
        if (i_item.func) begin
            if (r_phase != i2cmw_pkg::PH_IDLE) begin
                w_rej = 1'b1;
            end else begin
                n_shift   = {i_item.device_address, 1'b0};
                n_reg_idx = i_item.register_index;
                n_wdata   = i_item.write_data;
                n_byte    = '0;
                n_bit     = '0;
                n_sda_oe  = 1'b1;
                n_sda_lvl = 1'b1;
                n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_START_HI, i_tpu);
                n_phase   = i2cmw_pkg::PH_START_HI;
            end
        end else if (r_phase != i2cmw_pkg::PH_IDLE) begin
            if (r_wait > i2cmw_pkg::WAIT_W'(1)) begin
                n_wait = r_wait - i2cmw_pkg::WAIT_W'(1);
            end else begin
                case (r_phase)
                    i2cmw_pkg::PH_START_HI: begin
                        n_sda_lvl = 1'b0;
                        n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_START_LO, i_tpu);
                        n_phase   = i2cmw_pkg::PH_START_LO;
                    end
                    i2cmw_pkg::PH_START_LO: begin
                        n_scl_low = 1'b1;
                        n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_BIT_LOW, i_tpu);
                        n_phase   = i2cmw_pkg::PH_BIT_LOW;
                    end
                    i2cmw_pkg::PH_BIT_LOW: begin
                        n_sda_oe  = 1'b1;
                        n_sda_lvl = r_shift[7];
                        n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_BIT_SETUP, i_tpu);
                        n_phase   = i2cmw_pkg::PH_BIT_SETUP;
                    end
                    i2cmw_pkg::PH_BIT_SETUP: begin
                        n_scl_low = 1'b0;
                        n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_BIT_HIGH, i_tpu);
                        n_phase   = i2cmw_pkg::PH_BIT_HIGH;
                    end
                    i2cmw_pkg::PH_BIT_HIGH: begin
                        n_shift = {r_shift[6:0], 1'b0};
                        if (r_bit == 3'd7) begin
                            n_bit     = '0;
                            n_scl_low = 1'b1;
                            n_sda_oe  = 1'b1;
                            n_sda_lvl = 1'b0;
                            n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_ACK, i_tpu);
                            n_phase   = i2cmw_pkg::PH_ACK_LOW;
                        end else begin
                            n_bit     = r_bit + 3'd1;
                            n_scl_low = 1'b1;
                            n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_BIT_LOW, i_tpu);
                            n_phase   = i2cmw_pkg::PH_BIT_LOW;
                        end
                    end
                    i2cmw_pkg::PH_ACK_LOW: begin
                        n_scl_low = 1'b0;
                        n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_ACK, i_tpu);
                        n_phase   = i2cmw_pkg::PH_ACK_HIGH;
                    end
                    i2cmw_pkg::PH_ACK_HIGH: begin
                        if (r_byte >= 2'd2) begin
                            n_wait  = i2cmw_pkg::load_wait(i2cmw_pkg::US_STOP_PRE, i_tpu);
                            n_phase = i2cmw_pkg::PH_STOP_PRE;
                        end else begin
                            n_byte    = r_byte + 2'd1;
                            n_shift   = (r_byte == 2'd0) ? r_reg_idx : r_wdata;
                            n_bit     = '0;
                            n_scl_low = 1'b1;
                            n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_BIT_LOW, i_tpu);
                            n_phase   = i2cmw_pkg::PH_BIT_LOW;
                        end
                    end
                    i2cmw_pkg::PH_STOP_PRE: begin
                        n_scl_low = 1'b1;
                        n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_STOP_LOW, i_tpu);
                        n_phase   = i2cmw_pkg::PH_STOP_LOW;
                    end
                    i2cmw_pkg::PH_STOP_LOW: begin
                        n_scl_low = 1'b0;
                        n_wait    = i2cmw_pkg::load_wait(i2cmw_pkg::US_STOP_HIGH, i_tpu);
                        n_phase   = i2cmw_pkg::PH_STOP_HIGH;
                    end
                    i2cmw_pkg::PH_STOP_HIGH: begin
                        n_sda_lvl = 1'b1;
                        n_wait    = '0;
                        n_phase   = i2cmw_pkg::PH_IDLE;
                        w_done    = 1'b1;
                    end
                    default: begin
                        n_wait  = '0;
                        n_phase = i2cmw_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_res.scl_held_low     = n_scl_low;
        o_res.sda_driven       = n_sda_oe;
        o_res.sda_value        = n_sda_lvl;
        o_res.busy_res         = (n_phase != i2cmw_pkg::PH_IDLE);
        o_res.done_res         = w_done;
        o_res.request_rejected = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2cmw_pkg::PH_IDLE;
            r_byte    <= '0;
            r_bit     <= '0;
            r_wait    <= '0;
            r_shift   <= '0;
            r_reg_idx <= '0;
            r_wdata   <= '0;
            r_scl_low <= 1'b0;
            r_sda_oe  <= 1'b0;
            r_sda_lvl <= 1'b1;
        end else if (i_ce) begin
            r_phase   <= n_phase;
            r_byte    <= n_byte;
            r_bit     <= n_bit;
            r_wait    <= n_wait;
            r_shift   <= n_shift;
            r_reg_idx <= n_reg_idx;
            r_wdata   <= n_wdata;
            r_scl_low <= n_scl_low;
            r_sda_oe  <= n_sda_oe;
            r_sda_lvl <= n_sda_lvl;
        end
    end

`ifndef ASSERT_OFF
    a_done_from_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ce && o_res.done_res) |-> (r_phase == i2cmw_pkg::PH_STOP_HIGH))
        else $error("done without stop phase");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ce && o_res.request_rejected) |-> (r_phase != i2cmw_pkg::PH_IDLE))
        else $error("request rejected while idle");

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait <= i2cmw_pkg::WAIT_MAX)
        else $error("wait count out of range");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ce && i_item.func && (r_phase == i2cmw_pkg::PH_IDLE))
        |=> (r_phase == i2cmw_pkg::PH_START_HI) && r_sda_oe && r_sda_lvl)
        else $error("request did not open start phase");

    a_idle_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == i2cmw_pkg::PH_IDLE) |-> (r_wait == '0))
        else $error("wait count left over in idle");
`endif

endmodule

// ===== src/i2cmw_res_reg.sv =====
module i2cmw_res_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  i2cmw_pkg::t_out_item  i_item,
    output logic                  o_load_ok,
    output logic                  o_valid,
    input  logic                  i_ready,
    output i2cmw_pkg::t_out_item  o_item
);

    logic                  r_valid;
    i2cmw_pkg::t_out_item  r_item;

    assign o_load_ok = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_item    = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== src/i2c_master_register_write_top.sv =====
// Tick-driven I2C master for one three-byte register write.
// Input channel (i_in_valid/o_in_ready/i_in_item): func 1 requests a write of
// write_data to register_index at device_address; func 0 is one time tick.
// Every input item yields exactly one result item on the output channel
// (o_out_valid/i_out_ready/o_out_item) with the SCL/SDA line controls, busy,
// done and request_rejected, all as they stand after that item.
// Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data): ticks per microsecond,
// always ready; write it only while no transaction or item is in flight.
// An accepted item waits in the input register and is processed into the result
// register when that register can take it; its result is then offered there.
// Throughput: one item per cycle while the receiver takes results, set by the
// sequencer update between the input register and the result register.
// When the receiver stalls, the result register holds, the input register
// fills and o_in_ready drops until the result is taken.
// Reset: lines released with SDA level high, sequencer idle, both registers
// empty, ticks per microsecond set to one.
module i2c_master_register_write_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  i2cmw_pkg::t_in_item          i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output i2cmw_pkg::t_out_item         o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [i2cmw_pkg::TPU_W-1:0]  i_cfg_data
);

    logic                         r_in_valid;
    i2cmw_pkg::t_in_item          r_in_item;
    logic [i2cmw_pkg::TPU_W-1:0]  r_tpu;
    logic                         w_load_ok;
    logic                         w_adv;
    i2cmw_pkg::t_out_item         w_res;

    assign o_cfg_ready = 1'b1;
    assign w_adv       = r_in_valid && w_load_ok;
    assign o_in_ready  = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu <= i2cmw_pkg::TPU_W'(1);
        end else if (i_cfg_valid) begin
            r_tpu <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    i2cmw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_adv),
        .i_item  (r_in_item),
        .i_tpu   (r_tpu),
        .o_res   (w_res)
    );

    i2cmw_res_reg u_res_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_adv),
        .i_item    (w_res),
        .o_load_ok (w_load_ok),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_TICK      = 1'b0;
    localparam logic FUNC_REQUEST   = 1'b1;
    localparam int   MAX_GAP        = 12;
    localparam int   SETTLE         = 4;
    localparam int   STALL_LIMIT    = 1000;
    localparam int   LONG_RUN_TICKS = 24;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          in_valid;
    logic                          o_in_ready;
    i2cmw_pkg::t_in_item           in_item;
    logic                          o_out_valid;
    logic                          out_ready;
    i2cmw_pkg::t_out_item          o_out_item;
    logic                          cfg_valid;
    logic                          o_cfg_ready;
    logic [i2cmw_pkg::TPU_W-1:0]   cfg_data;

    // predicted sequencer state
    logic [i2cmw_pkg::TPU_W-1:0]   tpu_setting;
    i2cmw_pkg::t_phase             sq_phase;
    logic [1:0]                    sq_byte;
    logic [2:0]                    sq_bit;
    logic [i2cmw_pkg::WAIT_W-1:0]  sq_wait;
    logic [7:0]                    sq_shift;
    logic [7:0]                    sq_reg;
    logic [7:0]                    sq_data;
    logic                          scl_low;
    logic                          sda_oe;
    logic                          sda_lvl;

    i2cmw_pkg::t_out_item          expected_lines[$];
    bit                            pace_gaps;
    int                            mismatches;
    int                            items_sent;
    int                            results_checked;
    int                            writes_done;
    int                            turned_away;

    i2c_master_register_write_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [i2cmw_pkg::WAIT_W-1:0] us_to_ticks(
        input logic [i2cmw_pkg::US_W-1:0] us
    );
        logic [i2cmw_pkg::WAIT_W-1:0] per_us;
        per_us = (tpu_setting == '0) ? i2cmw_pkg::WAIT_W'(1)
                                     : i2cmw_pkg::WAIT_W'(tpu_setting);
        return per_us * i2cmw_pkg::WAIT_W'(us);
    endfunction

    function automatic void open_bit_slot();
        scl_low  = 1'b1;
        sq_wait  = us_to_ticks(i2cmw_pkg::US_BIT_LOW);
        sq_phase = i2cmw_pkg::PH_BIT_LOW;
    endfunction

    function automatic logic advance_phase();
        logic finished;
        finished = 1'b0;
        case (sq_phase)
            i2cmw_pkg::PH_START_HI: begin
                sda_lvl  = 1'b0;
                sq_wait  = us_to_ticks(i2cmw_pkg::US_START_LO);
                sq_phase = i2cmw_pkg::PH_START_LO;
            end
            i2cmw_pkg::PH_START_LO: open_bit_slot();
            i2cmw_pkg::PH_BIT_LOW: begin
                sda_oe   = 1'b1;
                sda_lvl  = sq_shift[7];
                sq_wait  = us_to_ticks(i2cmw_pkg::US_BIT_SETUP);
                sq_phase = i2cmw_pkg::PH_BIT_SETUP;
            end
            i2cmw_pkg::PH_BIT_SETUP: begin
                scl_low  = 1'b0;
                sq_wait  = us_to_ticks(i2cmw_pkg::US_BIT_HIGH);
                sq_phase = i2cmw_pkg::PH_BIT_HIGH;
            end
            i2cmw_pkg::PH_BIT_HIGH: begin
                sq_shift = sq_shift << 1;
                if (sq_bit == 3'd7) begin
                    sq_bit   = '0;
                    scl_low  = 1'b1;
                    sda_oe   = 1'b1;
                    sda_lvl  = 1'b0;
                    sq_wait  = us_to_ticks(i2cmw_pkg::US_ACK);
                    sq_phase = i2cmw_pkg::PH_ACK_LOW;
                end else begin
                    sq_bit = sq_bit + 3'd1;
                    open_bit_slot();
                end
            end
            i2cmw_pkg::PH_ACK_LOW: begin
                scl_low  = 1'b0;
                sq_wait  = us_to_ticks(i2cmw_pkg::US_ACK);
                sq_phase = i2cmw_pkg::PH_ACK_HIGH;
            end
            i2cmw_pkg::PH_ACK_HIGH: begin
                if (sq_byte >= 2'd2) begin
                    sq_wait  = us_to_ticks(i2cmw_pkg::US_STOP_PRE);
                    sq_phase = i2cmw_pkg::PH_STOP_PRE;
                end else begin
                    sq_byte  = sq_byte + 2'd1;
                    sq_shift = (sq_byte == 2'd1) ? sq_reg : sq_data;
                    sq_bit   = '0;
                    open_bit_slot();
                end
            end
            i2cmw_pkg::PH_STOP_PRE: begin
                scl_low  = 1'b1;
                sq_wait  = us_to_ticks(i2cmw_pkg::US_STOP_LOW);
                sq_phase = i2cmw_pkg::PH_STOP_LOW;
            end
            i2cmw_pkg::PH_STOP_LOW: begin
                scl_low  = 1'b0;
                sq_wait  = us_to_ticks(i2cmw_pkg::US_STOP_HIGH);
                sq_phase = i2cmw_pkg::PH_STOP_HIGH;
            end
            i2cmw_pkg::PH_STOP_HIGH: begin
                sda_lvl  = 1'b1;
                sq_wait  = '0;
                sq_phase = i2cmw_pkg::PH_IDLE;
                finished = 1'b1;
            end
            default: begin
                sq_wait  = '0;
                sq_phase = i2cmw_pkg::PH_IDLE;
            end
        endcase
        return finished;
    endfunction

    function automatic i2cmw_pkg::t_out_item predict_lines(input i2cmw_pkg::t_in_item it);
        i2cmw_pkg::t_out_item line;
        logic                 finished;
        logic                 refused;
        finished = 1'b0;
        refused  = 1'b0;
        if (it.func == FUNC_REQUEST) begin
            if (sq_phase != i2cmw_pkg::PH_IDLE) begin
                refused = 1'b1;
                turned_away++;
            end else begin
                sq_shift = {it.device_address, 1'b0};
                sq_reg   = it.register_index;
                sq_data  = it.write_data;
                sq_byte  = '0;
                sq_bit   = '0;
                sda_oe   = 1'b1;
                sda_lvl  = 1'b1;
                sq_wait  = us_to_ticks(i2cmw_pkg::US_START_HI);
                sq_phase = i2cmw_pkg::PH_START_HI;
            end
        end else if (sq_phase != i2cmw_pkg::PH_IDLE) begin
            if (sq_wait > i2cmw_pkg::WAIT_W'(1))
                sq_wait = sq_wait - i2cmw_pkg::WAIT_W'(1);
            else
                finished = advance_phase();
        end
        if (finished)
            writes_done++;
        line.scl_held_low     = scl_low;
        line.sda_driven       = sda_oe;
        line.sda_value        = sda_lvl;
        line.busy_res         = (sq_phase != i2cmw_pkg::PH_IDLE);
        line.done_res         = finished;
        line.request_rejected = refused;
        return line;
    endfunction

    function automatic i2cmw_pkg::t_in_item tick_item();
        i2cmw_pkg::t_in_item it;
        it.func           = FUNC_TICK;
        it.device_address = 7'($urandom);
        it.register_index = 8'($urandom);
        it.write_data     = 8'($urandom);
        return it;
    endfunction

    function automatic i2cmw_pkg::t_in_item random_request();
        i2cmw_pkg::t_in_item it;
        it.func           = FUNC_REQUEST;
        it.device_address = 7'($urandom);
        it.register_index = 8'($urandom);
        it.write_data     = 8'($urandom);
        return it;
    endfunction

    task automatic send_item(input i2cmw_pkg::t_in_item it);
        int gap;
        gap = pace_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        expected_lines.push_back(predict_lines(it));
        items_sent++;
    endtask

    task automatic finish_transfer(input int reject_pct);
        while (sq_phase != i2cmw_pkg::PH_IDLE) begin
            if ($urandom_range(0, 99) < reject_pct)
                send_item(random_request());
            else
                send_item(tick_item());
        end
    endtask

    task automatic settle_and_set_tpu(input logic [i2cmw_pkg::TPU_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        tpu_setting = value;
    endtask

    task automatic test_idle_ticks();
        send_item(i2cmw_pkg::t_in_item'{FUNC_TICK, 7'h7f, 8'hff, 8'hff});
        send_item(i2cmw_pkg::t_in_item'{FUNC_TICK, 7'h00, 8'h00, 8'h00});
        send_item(tick_item());
    endtask

    task automatic test_extreme_requests();
        settle_and_set_tpu(i2cmw_pkg::TPU_W'(1));
        send_item(i2cmw_pkg::t_in_item'{FUNC_REQUEST, 7'h7f, 8'hff, 8'hff});
        send_item(tick_item());
        send_item(i2cmw_pkg::t_in_item'{FUNC_REQUEST, 7'h00, 8'h00, 8'h00});
        finish_transfer(0);
        send_item(i2cmw_pkg::t_in_item'{FUNC_REQUEST, 7'h55, 8'haa, 8'h55});
        send_item(i2cmw_pkg::t_in_item'{FUNC_REQUEST, 7'h7f, 8'hff, 8'hff});
        finish_transfer(0);
        send_item(tick_item());
    endtask

    task automatic test_zero_tpu();
        settle_and_set_tpu('0);
        send_item(random_request());
        finish_transfer(2);
    endtask

    task automatic test_random_traffic(input logic [i2cmw_pkg::TPU_W-1:0] tpu,
                                       input bit gaps, input int count);
        int sent;
        settle_and_set_tpu(tpu);
        pace_gaps = gaps;
        sent = 0;
        while (sent < count) begin
            if (sq_phase == i2cmw_pkg::PH_IDLE)
                send_item(($urandom_range(0, 99) < 85) ? random_request() : tick_item());
            else
                send_item(($urandom_range(0, 99) < 3) ? random_request() : tick_item());
            sent++;
        end
        finish_transfer(3);
        pace_gaps = 1'b1;
    endtask

    task automatic test_max_tpu();
        settle_and_set_tpu(i2cmw_pkg::TPU_W'(1023));
        pace_gaps = 1'b0;
        send_item(random_request());
        repeat (LONG_RUN_TICKS) send_item(tick_item());
        send_item(random_request());
        pace_gaps = 1'b1;
    endtask

    task automatic compare_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        i2cmw_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_lines.size() == 0) begin
                $error("result item with nothing expected: %b", o_out_item);
                mismatches++;
            end else begin
                want = expected_lines.pop_front();
                compare_field("scl_held_low", want.scl_held_low, o_out_item.scl_held_low);
                compare_field("sda_driven", want.sda_driven, o_out_item.sda_driven);
                compare_field("sda_value", want.sda_value, o_out_item.sda_value);
                compare_field("busy_res", want.busy_res, o_out_item.busy_res);
                compare_field("done_res", want.done_res, o_out_item.done_res);
                compare_field("request_rejected", want.request_rejected,
                              o_out_item.request_rejected);
                results_checked++;
            end
        end
    end

    initial begin : result_sink
        int stall;
        out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = pace_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        pace_gaps = 1'b1;
        mismatches = 0;
        items_sent = 0;
        results_checked = 0;
        writes_done = 0;
        turned_away = 0;
        tpu_setting = i2cmw_pkg::TPU_W'(1);
        sq_phase = i2cmw_pkg::PH_IDLE;
        sq_byte  = '0;
        sq_bit   = '0;
        sq_wait  = '0;
        sq_shift = '0;
        sq_reg   = '0;
        sq_data  = '0;
        scl_low  = 1'b0;
        sda_oe   = 1'b0;
        sda_lvl  = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_extreme_requests();
        test_zero_tpu();
        test_random_traffic(i2cmw_pkg::TPU_W'(1), 1'b0, 100);
        test_random_traffic(i2cmw_pkg::TPU_W'(2), 1'b1, 100);
        test_max_tpu();

        in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d items, checked %0d results: %0d writes completed, %0d refused",
                 items_sent, results_checked, writes_done, turned_away);
        $display("Full writes at 0, 1 and 2 ticks per microsecond, a partial one at 1023");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== i2c_master_register_write_top.f =====
src/i2cmw_pkg.sv
src/i2cmw_seq.sv
src/i2cmw_res_reg.sv
src/i2c_master_register_write_top.sv
verif/tb_top.sv
